/* hdl/rgb_window_3x3_replicate_edges_assert.svh */
// ----------------------------------------------------------------------------
// rgb_window_3x3_replicate_edges assertion macros
// Shared property macros for the window generator checks.
// ----------------------------------------------------------------------------
`ifndef RGB_WINDOW_3X3_REPLICATE_EDGES_ASSERT_SVH
`define RGB_WINDOW_3X3_REPLICATE_EDGES_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RGBW3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbw3 check failed");

// next-cycle implication, sampled on clk, off during rst
`define RGBW3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbw3 check failed");

`endif

/* hdl/rgbw3_pkg.sv */
// ----------------------------------------------------------------------------
// rgbw3_pkg
// Types and constants of the 3x3 RGB window generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbw3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd2048;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1944;

  // window column codes on column_index
  localparam logic [1:0] COL_LEFT   = 2'd0;
  localparam logic [1:0] COL_CENTRE = 2'd1;
  localparam logic [1:0] COL_RIGHT  = 2'd2;

  typedef logic [7:0] channel_t;

  typedef struct packed {
    channel_t red;
    channel_t green;
    channel_t blue;
  } pixel_t;

  // line store entry: older row above newer row
  localparam int LINE_W = 2 * $bits(pixel_t);

  typedef struct packed {
    logic x_ge1;
    logic x_ge2;
    logic x_last;
    logic y_ge1;
    logic y_ge2;
    logic y_last;
  } pos_flags_t;

  typedef enum logic [2:0] {
    ROW_UPPER  = 3'b001,
    ROW_MIDDLE = 3'b010,
    ROW_RECENT = 3'b100
  } row_sel_t;

endpackage

`default_nettype wire

/* hdl/rgbw3_ram.sv */
// ----------------------------------------------------------------------------
// rgbw3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbw3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write to the same address returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/rgb_window_3x3_replicate_edges.sv */
// ----------------------------------------------------------------------------
// rgb_window_3x3_replicate_edges
// 3x3 RGB neighborhood generator over a raster stream, borders replicated.
// ----------------------------------------------------------------------------
// Path: an accepted pixel item is registered in stage 1, then shifted into the
//   window column registers, which offer its first column result.
// Throughput: one column result per cycle while window_ready is high; a pixel
//   completes 0 to 4 windows; stage 1 holds the next pixel while they go out.
// Reset: counters clear, width 2048, height 1944; line store contents stay
//   undefined (stale reads are masked by row flags), no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_window_3x3_replicate_edges (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              write_enable,
  input  logic [rgbw3_pkg::CFG_INDEX_W-1:0] register_index,
  input  logic [rgbw3_pkg::CFG_DATA_W-1:0]  write_data,
  // pixel channel
  input  logic                              pixel_valid,
  output logic                              pixel_ready,
  input  logic [7:0]                        red,
  input  logic [7:0]                        green,
  input  logic [7:0]                        blue,
  // window channel
  output logic                              window_valid,
  input  logic                              window_ready,
  output logic [7:0]                        top_red,
  output logic [7:0]                        top_green,
  output logic [7:0]                        top_blue,
  output logic [7:0]                        mid_red,
  output logic [7:0]                        mid_green,
  output logic [7:0]                        mid_blue,
  output logic [7:0]                        low_red,
  output logic [7:0]                        low_green,
  output logic [7:0]                        low_blue,
  output logic [1:0]                        column_index,
  output logic                              run_last
);

  import rgbw3_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers and effective size (0 acts as 1, clamp to max)
  // --------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [COL_W-1:0]        col_last;
  logic [ROW_W-1:0]        row_last;
  logic                    cfg_hit;

  assign cfg_hit = write_enable &&
                   ((reg_index_t'(register_index) == REG_IMAGE_WIDTH) ||
                    (reg_index_t'(register_index) == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (write_enable) begin
      case (reg_index_t'(register_index))
        REG_IMAGE_WIDTH:  image_width  <= write_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= write_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      col_last = '0;
    end else if (int'(image_width) > MAX_WIDTH) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(image_width - 1'b1);
    end
    if (image_height == '0) begin
      row_last = '0;
    end else if (int'(image_height) > MAX_HEIGHT) begin
      row_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_W'(image_height - 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: raster position, line store read issued at accept
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic             pixel_accept;
  pos_flags_t       cur_flags;

  assign pixel_accept = pixel_valid && pixel_ready;

  always_comb begin
    cur_flags.x_ge1  = (column_count != '0);
    cur_flags.x_ge2  = (column_count > COL_W'(1));
    cur_flags.x_last = (column_count == col_last);
    cur_flags.y_ge1  = (row_count != '0);
    cur_flags.y_ge2  = (row_count > ROW_W'(1));
    cur_flags.y_last = (row_count == row_last);
  end

  // any register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_hit) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pixel_accept) begin
      if (cur_flags.x_last) begin
        column_count <= '0;
        row_count    <= cur_flags.y_last ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line data back from RAM, column shift, write-back
  // --------------------------------------------------------------------------
  logic              s1_valid;
  logic              s1_done;
  pixel_t            s1_pix;
  logic [COL_W-1:0]  s1_addr;
  pos_flags_t        s1_flags;

  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] ram_wdata;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] fwd_data;
  logic              fwd_hit;
  pixel_t            line_older;
  pixel_t            line_newer;

  assign pixel_ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_pix   <= '{red: red, green: green, blue: blue};
      s1_addr  <= column_count;
      s1_flags <= cur_flags;
    end
  end

  // Width 1: every pixel hits entry 0, so the read issued at the edge of the
  // previous write-back misses it. Keep that write and use it instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (pixel_accept) begin
      fwd_hit <= s1_done && (s1_addr == column_count);
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      fwd_data <= ram_wdata;
    end
  end

  assign line_rd    = fwd_hit ? fwd_data : ram_rdata;
  assign line_older = line_rd[LINE_W-1:LINE_W/2];
  assign line_newer = line_rd[LINE_W/2-1:0];

  // entry moves up one row: older <= newer, newer <= this pixel
  assign ram_wdata = {line_newer, s1_pix};

  rgbw3_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_done),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (pixel_accept),
    .raddr (column_count),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Window columns: index 2 is the newest column
  // --------------------------------------------------------------------------
  pixel_t upper_cols  [3];
  pixel_t middle_cols [3];
  pixel_t recent_pix  [3];

  always_ff @(posedge clk) begin
    if (s1_done) begin
      upper_cols[0]  <= upper_cols[1];
      upper_cols[1]  <= upper_cols[2];
      upper_cols[2]  <= s1_flags.y_ge2 ? line_older : '0;
      middle_cols[0] <= middle_cols[1];
      middle_cols[1] <= middle_cols[2];
      middle_cols[2] <= s1_flags.y_ge1 ? line_newer : '0;
      recent_pix[0]  <= recent_pix[1];
      recent_pix[1]  <= recent_pix[2];
      recent_pix[2]  <= s1_pix;
    end
  end

  // --------------------------------------------------------------------------
  // Emitter: pending windows in raster order of their centre
  //   bit 0: centre (y-1, x-1)   bit 1: centre (y-1, x)  (right edge)
  //   bit 2: centre (y,   x-1)   bit 3: centre (y,   x)  (bottom row)
  // The column registers hold still until the last result is taken.
  // --------------------------------------------------------------------------
  logic [3:0] em_pending;
  logic [3:0] em_cur_bit;
  logic [1:0] em_k;
  pos_flags_t em_flags;
  logic       em_final;
  logic       em_rr;
  logic       em_cc;
  row_sel_t   top_sel;
  row_sel_t   mid_sel;
  logic [1:0] col_sel;
  pixel_t     top_pix;
  pixel_t     mid_pix;
  pixel_t     low_pix;

  assign window_valid = |em_pending;
  assign em_cur_bit   = em_pending & (~em_pending + 4'd1);
  assign em_final     = window_valid && (em_k == COL_RIGHT) &&
                        ((em_pending & (em_pending - 4'd1)) == 4'd0);
  assign s1_done      = s1_valid && (!window_valid || (em_final && window_ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      em_pending <= '0;
      em_k       <= COL_LEFT;
    end else if (s1_done) begin
      em_pending <= {s1_flags.y_last & s1_flags.x_last,
                     s1_flags.y_last & s1_flags.x_ge1,
                     s1_flags.y_ge1  & s1_flags.x_last,
                     s1_flags.y_ge1  & s1_flags.x_ge1};
      em_k       <= COL_LEFT;
    end else if (window_valid && window_ready) begin
      if (em_k == COL_RIGHT) begin
        em_pending <= em_pending & ~em_cur_bit;
        em_k       <= COL_LEFT;
      end else begin
        em_k       <= em_k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      em_flags <= s1_flags;
    end
  end

  function automatic pixel_t pick(input row_sel_t r, input logic [1:0] c,
                                  input pixel_t u0, input pixel_t u1,
                                  input pixel_t u2, input pixel_t m0,
                                  input pixel_t m1, input pixel_t m2,
                                  input pixel_t n0, input pixel_t n1,
                                  input pixel_t n2);
    pixel_t a0;
    pixel_t a1;
    pixel_t a2;
    pixel_t res;
    case (r)
      ROW_UPPER: begin
        a0 = u0; a1 = u1; a2 = u2;
      end
      ROW_MIDDLE: begin
        a0 = m0; a1 = m1; a2 = m2;
      end
      default: begin
        a0 = n0; a1 = n1; a2 = n2;
      end
    endcase
    case (c)
      COL_LEFT:   res = a0;
      COL_CENTRE: res = a1;
      default:    res = a2;
    endcase
    return res;
  endfunction

  always_comb begin
    // bottom-row windows once the upper half is done
    em_rr = !(em_pending[0] || em_pending[1]);
    em_cc = em_rr ? !em_pending[2] : !em_pending[0];

    // top row clamps down at the image top
    if (em_rr) begin
      top_sel = em_flags.y_ge1 ? ROW_MIDDLE : ROW_RECENT;
      mid_sel = ROW_RECENT;
    end else begin
      top_sel = em_flags.y_ge2 ? ROW_UPPER : ROW_MIDDLE;
      mid_sel = ROW_MIDDLE;
    end

    // left column clamps right at the image left edge, right column at the
    // right edge reuses the newest column
    case (em_k)
      COL_LEFT: begin
        if (em_cc) begin
          col_sel = em_flags.x_ge1 ? COL_CENTRE : COL_RIGHT;
        end else begin
          col_sel = em_flags.x_ge2 ? COL_LEFT : COL_CENTRE;
        end
      end
      COL_CENTRE: col_sel = em_cc ? COL_RIGHT : COL_CENTRE;
      default:    col_sel = COL_RIGHT;
    endcase

    top_pix = pick(top_sel, col_sel, upper_cols[0], upper_cols[1], upper_cols[2],
                   middle_cols[0], middle_cols[1], middle_cols[2],
                   recent_pix[0], recent_pix[1], recent_pix[2]);
    mid_pix = pick(mid_sel, col_sel, upper_cols[0], upper_cols[1], upper_cols[2],
                   middle_cols[0], middle_cols[1], middle_cols[2],
                   recent_pix[0], recent_pix[1], recent_pix[2]);
    low_pix = pick(ROW_RECENT, col_sel, upper_cols[0], upper_cols[1],
                   upper_cols[2], middle_cols[0], middle_cols[1],
                   middle_cols[2], recent_pix[0], recent_pix[1],
                   recent_pix[2]);
  end

  assign top_red      = top_pix.red;
  assign top_green    = top_pix.green;
  assign top_blue     = top_pix.blue;
  assign mid_red      = mid_pix.red;
  assign mid_green    = mid_pix.green;
  assign mid_blue     = mid_pix.blue;
  assign low_red      = low_pix.red;
  assign low_green    = low_pix.green;
  assign low_blue     = low_pix.blue;
  assign column_index = em_k;
  assign run_last     = em_final;

endmodule

`default_nettype wire

/* hdl/rgbw3_checker.sv */
// ----------------------------------------------------------------------------
// rgbw3_checker
// Port-level checks of the window channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_window_3x3_replicate_edges_assert.svh"

module rgbw3_checker (
  input logic       clk,
  input logic       rst,
  input logic       window_valid,
  input logic       window_ready,
  input logic [1:0] column_index,
  input logic       run_last
);

  import rgbw3_pkg::*;

  // a stalled item stays offered
  `RGBW3_ASSERT_NEXT(a_hold_valid, window_valid && !window_ready, window_valid)

  // a window's columns come out left, centre, right without a gap
  `RGBW3_ASSERT_NEXT(a_col_step, window_valid && window_ready && column_index != COL_RIGHT, window_valid && column_index == $past(column_index) + 2'd1)

  // the last item of a pixel closes a window
  `RGBW3_ASSERT_NOW(a_last_right, window_valid && run_last, column_index == COL_RIGHT)

  // further windows of the same pixel follow at once, starting left
  `RGBW3_ASSERT_NEXT(a_next_win, window_valid && window_ready && column_index == COL_RIGHT && !run_last, window_valid && column_index == COL_LEFT)

endmodule

bind rgb_window_3x3_replicate_edges rgbw3_checker u_rgbw3_checker (.*);

`default_nettype wire

/* tb/rgb_window_3x3_replicate_edges_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_window_3x3_replicate_edges_test
// Self-checking bench for the 3x3 RGB window generator. Pixel items go in
// through a valid/ready sender with random gaps. A scoreboard model in this
// file keeps its own line stores and window registers and queues the column
// results that every accepted pixel should cause. A monitor compares each
// accepted window column, field by field, against the oldest queued entry
// while the output side stalls at random. Frame sizes are reprogrammed
// between phases, including zero, clamped and masked register values.
// ----------------------------------------------------------------------------

module rgb_window_3x3_replicate_edges_test;
  import rgbw3_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;  // worst case is far below this
  localparam int RANDOM_PIXELS = 370;
  localparam int SETTLE_CYCLES = 8;       // first column shows up after stage 1 and the column registers
  localparam int MAX_PRINTS    = 40;

  // window column codes in order of k = 0, 1, 2
  localparam logic [1:0] COLUMN_CODE [3] = '{COL_LEFT, COL_CENTRE, COL_RIGHT};

  // order of register writes used when reprogramming the frame size
  typedef enum int {
    PROG_BOTH,
    PROG_WIDTH_ONLY,
    PROG_HEIGHT_ONLY,
    PROG_HEIGHT_FIRST
  } prog_order_t;

  // one column of an expected window
  typedef struct {
    pixel_t     top;
    pixel_t     mid;
    pixel_t     low;
    logic [1:0] column;
    logic       last;
  } window_col_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input holds a known value from time zero
  // --------------------------------------------------------------------------
  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   write_enable   = 1'b0;
  logic [CFG_INDEX_W-1:0] register_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  write_data     = '0;
  logic                   pixel_valid    = 1'b0;
  logic                   pixel_ready;
  logic [7:0]             red            = '0;
  logic [7:0]             green          = '0;
  logic [7:0]             blue           = '0;
  logic                   window_valid;
  logic                   window_ready   = 1'b0;
  logic [7:0]             top_red, top_green, top_blue;
  logic [7:0]             mid_red, mid_green, mid_blue;
  logic [7:0]             low_red, low_green, low_blue;
  logic [1:0]             column_index;
  logic                   run_last;

  // --------------------------------------------------------------------------
  // scoreboard state: own copy of registers, line stores and window columns
  // --------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  pixel_t                  line_two_up [MAX_WIDTH];  // row y-2
  pixel_t                  line_one_up [MAX_WIDTH];  // row y-1
  pixel_t                  win_upper [3];
  pixel_t                  win_middle [3];
  pixel_t                  win_lower [3];
  int unsigned             col_pos;
  int unsigned             row_pos;

  window_col_t             window_q [$];  // expected columns, oldest first

  int unsigned             err_count      = 0;
  int unsigned             pixels_sent    = 0;
  int unsigned             columns_seen   = 0;
  int unsigned             settings_used  = 0;
  int unsigned             cycle_count    = 0;
  int                      gap_pct        = 0;  // sender idle odds per item
  int                      stall_pct      = 0;  // receiver stall odds per cycle
  int                      stall_left     = 0;

  string channel_name [9] = '{"top_red", "top_green", "top_blue",
                              "mid_red", "mid_green", "mid_blue",
                              "low_red", "low_green", "low_blue"};

  // --------------------------------------------------------------------------
  // clock and DUT
  // --------------------------------------------------------------------------
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_window_3x3_replicate_edges u_top (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .pixel_valid    (pixel_valid),
    .pixel_ready    (pixel_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .window_valid   (window_valid),
    .window_ready   (window_ready),
    .top_red        (top_red),
    .top_green      (top_green),
    .top_blue       (top_blue),
    .mid_red        (mid_red),
    .mid_green      (mid_green),
    .mid_blue       (mid_blue),
    .low_red        (low_red),
    .low_green      (low_green),
    .low_blue       (low_blue),
    .column_index   (column_index),
    .run_last       (run_last)
  );

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  // mostly short idles, now and then a long one
  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // channel values lean toward the extremes now and then
  function automatic channel_t random_channel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red   = random_channel();
    p.green = random_channel();
    p.blue  = random_channel();
    return p;
  endfunction

  // zero acts as one, oversize clamps to the store size
  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  task automatic reset_scoreboard();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    col_pos    = 0;
    row_pos    = 0;
    foreach (line_two_up[i]) begin
      line_two_up[i] = '0;
      line_one_up[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      win_upper[i]  = '0;
      win_middle[i] = '0;
      win_lower[i]  = '0;
    end
  endtask

  // any register write restarts the frame at the top-left pixel
  task automatic apply_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = data[WIDTH_REG_W-1:0];
      REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
  endtask

  // ri: 0 or less = upper row, 1 = middle, 2 = newest; ci: window column
  function automatic pixel_t window_pixel(input int ri, input int ci);
    if (ri <= 0) return win_upper[ci];
    if (ri == 1) return win_middle[ci];
    return win_lower[ci];
  endfunction

  // Scoreboard step for one accepted pixel. A window is complete once its
  // clamped lower-right neighbor is the current pixel; up to four windows
  // (two rows x two columns of centres) finish here, in raster order.
  task automatic predict_windows(input pixel_t p);
    window_col_t batch [12];
    int unsigned w, h, x, y;
    int          n, r, top, bot, c, ci;
    int          cols [3];
    logic        row_ok, col_ok;
    w = active_width();
    h = active_height();
    x = col_pos;
    y = row_pos;
    if (x >= w) x = 0;
    if (y >= h) y = 0;

    win_upper[0]  = win_upper[1];
    win_upper[1]  = win_upper[2];
    win_upper[2]  = (y >= 2) ? line_two_up[x] : '0;
    win_middle[0] = win_middle[1];
    win_middle[1] = win_middle[2];
    win_middle[2] = (y >= 1) ? line_one_up[x] : '0;
    win_lower[0]  = win_lower[1];
    win_lower[1]  = win_lower[2];
    win_lower[2]  = p;
    line_two_up[x] = line_one_up[x];
    line_one_up[x] = p;

    n = 0;
    for (int rr = 0; rr < 2; rr++) begin
      // rr = 0: centre one row up; rr = 1: centre on the last row itself
      row_ok = (rr == 0) ? (y >= 1) : (y == h - 1);
      if (row_ok) begin
        r   = int'(y) - 1 + rr;
        top = (r > 0) ? r - 1 : 0;
        bot = (r + 1 > int'(h) - 1) ? int'(h) - 1 : r + 1;
        for (int cc = 0; cc < 2; cc++) begin
          col_ok = (cc == 0) ? (x >= 1) : (x == w - 1);
          if (col_ok) begin
            c       = int'(x) - 1 + cc;
            cols[0] = (c > 0) ? c - 1 : 0;
            cols[1] = c;
            cols[2] = (c + 1 > int'(w) - 1) ? int'(w) - 1 : c + 1;
            for (int k = 0; k < 3; k++) begin
              ci = cols[k] - int'(x) + 2;
              batch[n].top    = window_pixel(top - int'(y) + 2, ci);
              batch[n].mid    = window_pixel(r - int'(y) + 2, ci);
              batch[n].low    = window_pixel(bot - int'(y) + 2, ci);
              batch[n].column = COLUMN_CODE[k];
              batch[n].last   = 1'b0;
              n++;
            end
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      batch[i].last = (i == n - 1);
      window_q.insert(window_q.size(), batch[i]);
    end

    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endtask

  // --------------------------------------------------------------------------
  // sender side: one pixel item, with an optional idle gap ahead of it.
  // Valid stays high across back-to-back items; here it is only lowered for a gap.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_len() : 0;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red         <= p.red;
    green       <= p.green;
    blue        <= p.blue;
    do @(posedge clk); while (!pixel_ready);
    pixels_sent++;
    predict_windows(p);
  endtask

  // stop sending and let every expected column come out; a pixel that
  // finishes no window may still be in flight, hence the settle cycles
  task automatic drain_windows();
    pixel_valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes, back to back; the block must be idle when called
  task automatic program_frame(input logic [CFG_DATA_W-1:0] wdata,
                               input logic [CFG_DATA_W-1:0] hdata,
                               input prog_order_t order);
    reg_index_t            idx [2];
    logic [CFG_DATA_W-1:0] val [2];
    int                    cnt;
    case (order)
      PROG_WIDTH_ONLY: begin
        idx[0] = REG_IMAGE_WIDTH;  val[0] = wdata; cnt = 1;
      end
      PROG_HEIGHT_ONLY: begin
        idx[0] = REG_IMAGE_HEIGHT; val[0] = hdata; cnt = 1;
      end
      PROG_HEIGHT_FIRST: begin
        idx[0] = REG_IMAGE_HEIGHT; val[0] = hdata;
        idx[1] = REG_IMAGE_WIDTH;  val[1] = wdata; cnt = 2;
      end
      default: begin
        idx[0] = REG_IMAGE_WIDTH;  val[0] = wdata;
        idx[1] = REG_IMAGE_HEIGHT; val[1] = hdata; cnt = 2;
      end
    endcase
    for (int i = 0; i < cnt; i++) begin
      write_enable   <= 1'b1;
      register_index <= idx[i];
      write_data     <= val[i];
      @(posedge clk);
      apply_register(idx[i], val[i]);
    end
    write_enable <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // receiver side: random stalls, mostly short, with stall-free stretches
  // whenever a test sets stall_pct to zero
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      window_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      window_ready <= 1'b0;
      stall_left = pick_len() - 1;
    end else begin
      window_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: each accepted column against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_windows
    window_col_t want;
    logic [7:0]  got_ch [9];
    logic [7:0]  want_ch [9];
    if (!rst && window_valid && window_ready) begin
      if (window_q.size() == 0) begin
        report_mismatch("window column arrived with nothing expected");
      end else begin
        want    = window_q.pop_front();
        got_ch  = '{top_red, top_green, top_blue, mid_red, mid_green, mid_blue,
                    low_red, low_green, low_blue};
        want_ch = '{want.top.red, want.top.green, want.top.blue,
                    want.mid.red, want.mid.green, want.mid.blue,
                    want.low.red, want.low.green, want.low.blue};
        for (int i = 0; i < 9; i++) begin
          if (got_ch[i] !== want_ch[i]) begin
            report_mismatch($sformatf("column %0d: %s got %0d expected %0d",
                                      columns_seen, channel_name[i], got_ch[i], want_ch[i]));
          end
        end
        if (column_index !== want.column) begin
          report_mismatch($sformatf("column %0d: column_index got %0d expected %0d",
                                    columns_seen, column_index, want.column));
        end
        if (run_last !== want.last) begin
          report_mismatch($sformatf("column %0d: run_last got %0b expected %0b",
                                    columns_seen, run_last, want.last));
        end
      end
      columns_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d columns still expected",
               cycle_count, window_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset size is 2048 x 1944: the first row finishes no window at all
  task automatic test_reset_defaults();
    gap_pct   = 0;
    stall_pct = 0;
    send_pixel('{8'h00, 8'h00, 8'h00});
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
    send_pixel(random_pixel());
    drain_windows();
  endtask

  // zero width and height act as a 1x1 frame: every pixel is its own window
  task automatic test_single_pixel_frames();
    program_frame('0, '0, PROG_BOTH);
    send_pixel('{8'hFF, 8'h00, 8'hFF});
    send_pixel('{8'h00, 8'hFF, 8'h00});
    send_pixel(random_pixel());
    drain_windows();
  endtask

  // 2x2: the last pixel closes all four windows (twelve columns), and the
  // fifth pixel wraps into a new frame
  task automatic test_full_window_burst();
    program_frame(13'd2, 13'd2, PROG_HEIGHT_FIRST);
    stall_pct = 30;
    for (int i = 0; i < 5; i++) send_pixel(random_pixel());
    drain_windows();
  endtask

  // width above the store size clamps; bit 12 of the data is dropped
  task automatic test_width_clamp();
    program_frame(13'h1FFF, 13'd1, PROG_BOTH);
    gap_pct   = 30;
    stall_pct = 10;
    for (int i = 0; i < 6; i++) send_pixel(random_pixel());
    drain_windows();
  endtask

  // height above the limit clamps; one pixel per row
  task automatic test_height_clamp();
    program_frame(13'd1, 13'h1FFF, PROG_BOTH);
    for (int i = 0; i < 6; i++) send_pixel(random_pixel());
    drain_windows();
  endtask

  // random frame sizes, mostly small; frames run whole, twice, or stop
  // partway so the next write restarts mid-frame
  task automatic test_random_frames();
    int unsigned pick, w_data, h_data, w_eff, h_eff, count, drain_at, sent;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        w_data = $urandom_range(1, 8);
        h_data = $urandom_range(1, 6);
      end else if (pick < 80) begin
        w_data = $urandom_range(9, 40);
        h_data = $urandom_range(1, 4);
      end else if (pick < 90) begin
        w_data = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2049, 4095);
        h_data = $urandom_range(1, 2);
      end else begin
        w_data = $urandom_range(1, 3);
        h_data = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4097, 8191);
      end
      // width register is 12 bits wide; the top data bit must be ignored
      if ($urandom_range(0, 6) == 0) w_data = w_data | 32'h1000;
      program_frame(13'(w_data), 13'(h_data), prog_order_t'($urandom_range(0, 3)));

      w_eff = active_width();
      h_eff = active_height();
      count = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff);
      if (count > 80) count = $urandom_range(20, 80);
      if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      // sometimes hold off mid-frame until every column has come out
      drain_at  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, count) : count + 1;
      for (int i = 0; i < count; i++) begin
        if (i == drain_at) drain_windows();
        send_pixel(random_pixel());
      end
      sent += count;
      drain_windows();
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_scoreboard();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_single_pixel_frames();
    test_full_window_burst();
    test_width_clamp();
    test_height_clamp();
    test_random_frames();

    drain_windows();
    if (window_q.size() != 0) begin
      report_mismatch($sformatf("%0d window columns never arrived", window_q.size()));
    end

    $display("Sent %0d pixels over %0d frame settings; %0d window columns compared.",
             pixels_sent, settings_used, columns_seen);
    $display("Included 1x1 and 2x2 frames, clamped sizes, restarts and stalls on both sides.");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
